/* src/cpc_pkg.sv */
`default_nettype none

package cpc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned ATAN_COUNT        = 24;

  // angle accumulator: 2^32 units per full turn
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  // rounded phase codes, pi/32768 units, 16-bit two's complement wrap
  localparam logic [15:0] R_ZERO         = 16'h0000;
  localparam logic [15:0] R_HALF         = 16'h8000;
  localparam logic [15:0] R_QUARTER      = 16'h4000;
  localparam logic [15:0] R_NEG_QUARTER  = 16'hC000;
  localparam logic [15:0] HUE_FLIP       = 16'h8000;
  localparam logic [16:0] PHASE_MIN      = 17'h18000;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_COLOUR = 1'b1
  } cpc_op_e;

  typedef struct packed {
    cpc_op_e            op;
    logic [7:0]         table_index;
    logic [11:0]        load_red;
    logic [11:0]        load_green;
    logic [11:0]        load_blue;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } cpc_in_t;

  typedef struct packed {
    logic signed [16:0] phase_angle;
    logic [15:0]        hue_turns;
    logic [11:0]        colour_red;
    logic [11:0]        colour_green;
    logic [11:0]        colour_blue;
  } cpc_out_t;

  // per-word side info carried alongside the rotation datapath
  typedef struct packed {
    cpc_op_e     op;
    logic        axis;
    logic [15:0] axis_code;
    logic        load_ok;
    logic [7:0]  table_index;
    logic [11:0] load_red;
    logic [11:0] load_green;
    logic [11:0] load_blue;
  } cpc_side_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_unit(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051D;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2E;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2F9;
      15:      v = 32'h0000_517C;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A2F;
      19:      v = 32'h0000_0517;
      20:      v = 32'h0000_028B;
      21:      v = 32'h0000_0145;
      22:      v = 32'h0000_00A2;
      23:      v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/cpc_front.sv */
`default_nettype none

module cpc_front #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned XW            = SAMPLE_BITS + 3
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  cpc_pkg::cpc_in_t      data_i,
  output logic                  valid_o,
  input  wire                   ready_i,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic [31:0]           z_o,
  output cpc_pkg::cpc_side_t    side_o
);
  import cpc_pkg::*;

  logic [SAMPLE_BITS+15:0]  re_ext, im_ext;
  logic [SAMPLE_BITS-1:0]   re_raw, im_raw;
  logic signed [XW-1:0]     x0, y0;
  logic                     x_neg;
  logic                     valid_q;
  logic signed [XW-1:0]     x_d, y_d, x_q, y_q;
  logic [31:0]              z_d, z_q;
  cpc_side_t                side_d, side_q;

  always_comb begin
    // the field is taken as its raw 16-bit pattern, then sign extended from SAMPLE_BITS
    re_ext = (SAMPLE_BITS + 16)'($unsigned(data_i.sample_real));
    im_ext = (SAMPLE_BITS + 16)'($unsigned(data_i.sample_imag));
    re_raw = re_ext[SAMPLE_BITS-1:0];
    im_raw = im_ext[SAMPLE_BITS-1:0];
    x0     = XW'($signed(re_raw));
    y0     = XW'($signed(im_raw));
    x_neg  = x0[XW-1];

    // fold the left half plane onto the right one
    x_d = x_neg ? -x0 : x0;
    y_d = x_neg ? -y0 : y0;
    z_d = x_neg ? HALF_TURN : 32'h0;

    side_d.op          = data_i.op;
    side_d.axis        = (y0 == '0) || (x0 == '0);
    if (y0 == '0) begin
      side_d.axis_code = x_neg ? R_HALF : R_ZERO;
    end else begin
      side_d.axis_code = y0[XW-1] ? R_NEG_QUARTER : R_QUARTER;
    end
    side_d.load_ok     = {24'd0, data_i.table_index} < 32'(TABLE_ENTRIES);
    side_d.table_index = data_i.table_index;
    side_d.load_red    = data_i.load_red;
    side_d.load_green  = data_i.load_green;
    side_d.load_blue   = data_i.load_blue;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

  a_right_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !side_q.axis |-> !x_q[XW-1])
    else $error("rotation input left of the imaginary axis");

endmodule

`default_nettype wire

/* src/cpc_cordic_stage.sv */
`default_nettype none

module cpc_cordic_stage #(
  parameter int unsigned XW    = 19,
  parameter int unsigned STAGE = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  wire signed [XW-1:0]   x_i,
  input  wire signed [XW-1:0]   y_i,
  input  wire [31:0]            z_i,
  input  cpc_pkg::cpc_side_t    side_i,
  output logic                  valid_o,
  input  wire                   ready_i,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic [31:0]           z_o,
  output cpc_pkg::cpc_side_t    side_o
);
  import cpc_pkg::*;

  localparam logic [31:0] ATAN = atan_unit(STAGE);

  logic                 valid_q;
  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic [31:0]          z_d, z_q;
  cpc_side_t            side_q;
  logic                 y_pos;

  always_comb begin
    // arithmetic shift rounds toward minus infinity
    dx    = y_i >>> STAGE;
    dy    = x_i >>> STAGE;
    y_pos = !y_i[XW-1] && (y_i != '0);
    if (y_pos) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

/* src/cpc_colour_map.sv */
`default_nettype none

module cpc_colour_map #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire [31:0]          z_i,
  input  cpc_pkg::cpc_side_t  side_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output cpc_pkg::cpc_out_t   out_data_o
);
  import cpc_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW = 16 + IW + 1;

  // rounding stage
  logic        r_valid_q, r_ready;
  logic [31:0] z_round;
  logic [15:0] r_d, r_q;
  cpc_side_t   r_side_q;

  // index stage
  logic          i_valid_q, i_ready;
  logic [15:0]   hue;
  logic [PW-1:0] prod_idx;
  logic [PW-17:0] i0_wide;
  logic [IW-1:0] i0_d, i1_d, i0_q, i1_q;
  logic [15:0]   f_d, f_q, r_i_q;
  cpc_side_t     i_side_q;

  // table stage
  logic          m_valid_q, m_ready;
  logic [IW+7:0] wr_wide;
  logic [IW-1:0] wr_addr;
  logic [35:0]   wr_data;
  logic [35:0]   mem [TABLE_ENTRIES];
  logic [35:0]   rd0_q, rd1_q;
  logic [15:0]   f_m_q, r_m_q;

  // product stage
  logic               p_valid_q, p_ready;
  logic signed [12:0] diff [3];
  logic signed [16:0] f_s;
  logic signed [29:0] prod_d [3];
  logic signed [29:0] prod_q [3];
  logic [11:0]        c0_d [3];
  logic [11:0]        c0_q [3];
  logic [15:0]        r_p_q;

  // sum stage, holds the result word
  logic               s_valid_q, s_ready;
  logic signed [30:0] sum [3];
  logic [11:0]        chan [3];
  cpc_out_t           out_d, out_q;

  assign s_ready = !s_valid_q || out_ready_i;
  assign p_ready = !p_valid_q || s_ready;
  assign m_ready = !m_valid_q || p_ready;
  assign i_ready = !i_valid_q || m_ready;
  assign r_ready = !r_valid_q || i_ready;
  assign ready_o = r_ready;

  // round to pi/32768 units
  always_comb begin
    z_round = z_i + ROUND_HALF;
    r_d     = side_i.axis ? side_i.axis_code : z_round[31:16];
  end

  // hue and table position
  always_comb begin
    hue      = r_q ^ HUE_FLIP;
    prod_idx = PW'(hue) * PW'(TABLE_ENTRIES);
    i0_wide  = prod_idx[PW-1:16];
    i0_d     = i0_wide[IW-1:0];
    i1_d     = (i0_d == IW'(TABLE_ENTRIES - 1)) ? '0 : i0_d + IW'(1);
    f_d      = prod_idx[15:0];
  end

  always_comb begin
    wr_wide = (IW + 8)'(i_side_q.table_index);
    wr_addr = wr_wide[IW-1:0];
    wr_data = {i_side_q.load_red, i_side_q.load_green, i_side_q.load_blue};
  end

  // blend as c0 + (c1 - c0) * f
  always_comb begin
    f_s = $signed({1'b0, f_m_q});
    for (int k = 0; k < 3; k++) begin
      c0_d[k]   = rd0_q[35 - 12*k -: 12];
      diff[k]   = $signed({1'b0, rd1_q[35 - 12*k -: 12]}) - $signed({1'b0, c0_d[k]});
      prod_d[k] = 30'(diff[k]) * 30'(f_s);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]  = 31'(prod_q[k]) + $signed({3'b000, c0_q[k], 16'h8000});
      chan[k] = sum[k][27:16];
    end
    out_d.phase_angle  = $signed({r_p_q[15] && (r_p_q != R_HALF), r_p_q});
    out_d.hue_turns    = r_p_q ^ HUE_FLIP;
    out_d.colour_red   = chan[0];
    out_d.colour_green = chan[1];
    out_d.colour_blue  = chan[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      i_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (r_ready) r_valid_q <= valid_i;
      if (i_ready) i_valid_q <= r_valid_q;
      // drop load words here, they leave no result
      if (m_ready) m_valid_q <= i_valid_q && (i_side_q.op == OP_COLOUR);
      if (p_ready) p_valid_q <= m_valid_q;
      if (s_ready) s_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_ready && valid_i) begin
      r_q      <= r_d;
      r_side_q <= side_i;
    end
    if (i_ready && r_valid_q) begin
      i0_q     <= i0_d;
      i1_q     <= i1_d;
      f_q      <= f_d;
      r_i_q    <= r_q;
      i_side_q <= r_side_q;
    end
    if (m_ready && i_valid_q) begin
      f_m_q <= f_q;
      r_m_q <= r_i_q;
    end
    if (p_ready && m_valid_q) begin
      prod_q <= prod_d;
      c0_q   <= c0_d;
      r_p_q  <= r_m_q;
    end
    if (s_ready && p_valid_q) begin
      out_q <= out_d;
    end
  end

  // loads and lookups pass this point in arrival order
  always_ff @(posedge clk_i) begin
    if (m_ready && i_valid_q) begin
      if (i_side_q.op == OP_LOAD) begin
        if (i_side_q.load_ok) begin
          mem[wr_addr] <= wr_data;
        end
      end else begin
        rd0_q <= mem[i0_q];
        rd1_q <= mem[i1_q];
      end
    end
  end

  assign out_valid_o = s_valid_q;
  assign out_data_o  = out_q;

  a_hue_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> out_q.hue_turns == (out_q.phase_angle[15:0] ^ HUE_FLIP))
    else $error("hue does not follow phase");

  a_no_minus_pi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> out_q.phase_angle != PHASE_MIN)
    else $error("minus pi not folded");

  a_blend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !s_ready |=> p_valid_q && $stable(r_p_q))
    else $error("blend stage lost its word under stall");

endmodule

`default_nettype wire

/* src/complex_phase_to_colour.sv */
`default_nettype none

// Pipeline from input acceptance to result valid: one input stage, one stage per
// rotation, then round, index, table read, multiply, sum.
// Throughput: one word per cycle unless out_ready_i stalls; table loads travel the same
// pipeline and write at the table stage, so they take effect in order and produce no
// result word. Reset clears all valid bits; the colour table is undefined until loaded.
module complex_phase_to_colour #(
  parameter int unsigned TABLE_ENTRIES = cpc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned CORDIC_STAGES = cpc_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned SAMPLE_BITS   = cpc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  cpc_pkg::cpc_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output cpc_pkg::cpc_out_t  out_data_o
);
  import cpc_pkg::*;

  localparam int unsigned XW = SAMPLE_BITS + 3;

  logic                 vld [CORDIC_STAGES+1];
  logic                 rdy [CORDIC_STAGES+1];
  logic signed [XW-1:0] xs  [CORDIC_STAGES+1];
  logic signed [XW-1:0] ys  [CORDIC_STAGES+1];
  logic [31:0]          zs  [CORDIC_STAGES+1];
  cpc_side_t            sd  [CORDIC_STAGES+1];

  cpc_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .XW            (XW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .x_o     (xs[0]),
    .y_o     (ys[0]),
    .z_o     (zs[0]),
    .side_o  (sd[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    cpc_cordic_stage #(
      .XW    (XW),
      .STAGE (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .x_i     (xs[k]),
      .y_i     (ys[k]),
      .z_i     (zs[k]),
      .side_i  (sd[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .x_o     (xs[k+1]),
      .y_o     (ys[k+1]),
      .z_o     (zs[k+1]),
      .side_o  (sd[k+1])
    );
  end

  cpc_colour_map #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_colour_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld[CORDIC_STAGES]),
    .ready_o     (rdy[CORDIC_STAGES]),
    .z_i         (zs[CORDIC_STAGES]),
    .side_i      (sd[CORDIC_STAGES]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
